FILE: rtl/color_gradient_table_builder_macros.svh
// Assertion helpers shared by the gradient table builder RTL.
// In synthesis builds the macros expand to nothing.
`ifndef COLOR_GRADIENT_TABLE_BUILDER_MACROS_SVH
`define COLOR_GRADIENT_TABLE_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CGTB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cgtb assertion failed");
// Next-cycle implication.
`define CGTB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cgtb assertion failed");
`else
`define CGTB_ASSERT_IMP(label, clk, rst, ante, cons)
`define CGTB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/cgtb_pkg.sv
`default_nettype none

package cgtb_pkg;

  // Default sizes of the color table and of the power ROM.
  localparam int CGTB_TABLE_DEPTH   = 256;
  localparam int CGTB_POW_ROM_DEPTH = 1024;

  // Field widths.
  localparam int KIND_W     = 2;
  localparam int POS_W      = 32;
  localparam int RIDX_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int NUM_LANES  = 4;
  localparam int WORD_W     = COLOR_W * NUM_LANES;
  localparam int MODE_W     = 2;
  localparam int ROM_W      = 16;
  localparam int ROM_ROUND  = (2 ** ROM_W) - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Interpolation modes.
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 2'd2;

  // Configuration reset values.
  localparam logic [POS_W-1:0] RANGE_LOW_RST  = 32'd0;
  localparam logic [POS_W-1:0] RANGE_HIGH_RST = 32'd65280;

  // Control word from the sequencer to each channel lane.
  typedef struct packed {
    logic              start;
    logic              load;
    logic              step;
    logic [MODE_W-1:0] mode;
  } cgtb_lane_ctl_t;

  // Power ROM entry j: the largest y with y^5 * depth <= j * 2^80, which is
  // floor((j / depth)^0.2 * 65536). Evaluated at elaboration only.
  function automatic logic [ROM_W-1:0] pow_entry(input int unsigned j,
                                                 input int unsigned depth);
    logic [111:0] y;
    logic [111:0] p;
    logic [111:0] t;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    lo = 17'd0;
    hi = 17'd65535;
    t  = 112'(j) << 80;
    for (int s = 0; s < 17; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + 17'd1) >> 1;
        y   = 112'(mid);
        p   = y * y * y * y * y * 112'(depth);
        if (p <= t) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
    end
    return lo[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cgtb_in_if.sv
`default_nettype none

interface cgtb_in_if import cgtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [RIDX_W-1:0] read_index;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;
  logic [COLOR_W-1:0] in_alpha;

  modport source (
    output valid, kind, position, read_index, in_red, in_green, in_blue, in_alpha,
    input  ready
  );

  modport sink (
    input  valid, kind, position, read_index, in_red, in_green, in_blue, in_alpha,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cgtb_out_if.sv
`default_nettype none

interface cgtb_out_if import cgtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic [COLOR_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/color_gradient_table_builder.sv
// Gradient color table builder.
// Channels: "item" carries one command word (begin, control point or read),
// "result" returns one RGBA word for every command, zero except for reads.
// Configuration (range low/high, interpolation mode) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is idle, which the block does not enforce.
// Throughput: one command at a time. A control point passes through the
// clamp, index and setup states; when entries lie between it and the last
// point, the step divisions follow, the fill waits for the longer of them,
// and the fill pipeline then drains. The fill writes one table entry per
// cycle through the single write port of the table memory, all four
// channel lanes working side by side.
// Reset: the table is cleared by a pass that writes zero to every entry;
// item.ready stays low during it. The last point returns to index 0, color zero.
// A stalled receiver holds the result in the output register; one more
// command is accepted and then waits with its own result until it drains.
`default_nettype none
`include "color_gradient_table_builder_macros.svh"

module color_gradient_table_builder import cgtb_pkg::*; #(
  parameter int TABLE_DEPTH   = CGTB_TABLE_DEPTH,
  parameter int POW_ROM_DEPTH = CGTB_POW_ROM_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cgtb_in_if.sink               item,
  cgtb_out_if.source            result
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int PW   = $clog2(POW_ROM_DEPTH);
  localparam int EW   = PW + 1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_CLAMP  = 9'b000001000,
    ST_INDEX  = 9'b000010000,
    ST_SETUP  = 9'b000100000,
    ST_DIVIDE = 9'b001000000,
    ST_FILL   = 9'b010000000,
    ST_DRAIN  = 9'b100000000
  } cgtb_state_t;

  cgtb_state_t state;

  // The result of the current command waits for the output register.
  logic emit_pend;

  // Configuration registers.
  logic signed [POS_W-1:0] range_low;
  logic signed [POS_W-1:0] range_high;
  logic [MODE_W-1:0]       interp_mode;

  // Command registers.
  logic [KIND_W-1:0]       item_kind;
  logic signed [POS_W-1:0] item_pos;
  logic [RIDX_W-1:0]       item_read_index;
  logic [WORD_W-1:0]       item_color;

  // Point placement.
  logic signed [POS_W-1:0] clamp_calc;
  logic signed [POS_W-1:0] clamp_val;
  logic signed [POS_W:0]   idx_diff;
  logic [IDXW-1:0]         idx_calc;
  logic [IDXW-1:0]         new_idx;
  logic [IDXW-1:0]         prev_index;
  logic [WORD_W-1:0]       prev_color;
  logic [IDXW-1:0]         span;
  logic                    fill_needed;

  // Fill sequencing.
  logic [IDXW-1:0]         clr_addr;
  logic [IDXW-1:0]         fill_k;
  logic                    fill_load;
  logic                    s0_valid;
  logic [IDXW-1:0]         s0_addr;
  logic                    s1_valid;
  logic [IDXW-1:0]         s1_addr;
  logic                    s2_valid;
  logic [IDXW-1:0]         s2_addr;

  // Dividers and lanes.
  cgtb_lane_ctl_t          lane_ctl;
  logic [NUM_LANES-1:0]    lane_busy;
  logic [WORD_W-1:0]       lane_res;
  logic                    idx_busy;
  logic                    busy_any;
  logic [EW-1:0]           idx_quot;
  logic [IDXW-1:0]         idx_rem;

  // ROM index walk.
  logic [PW-1:0]           eidx;
  logic [IDXW-1:0]         er;
  logic [EW-1:0]           esq;
  logic [IDXW-1:0]         esr;
  logic [IDXW:0]           e_sum;
  logic [IDXW:0]           e_diff;
  logic                    e_wrap;
  logic [EW-1:0]           eidx_sum;
  logic [ROM_W-1:0]        pow_rom [POW_ROM_DEPTH];
  logic [ROM_W-1:0]        rom_q;

  // Table memory.
  logic [WORD_W-1:0]       store_mem [TABLE_DEPTH];
  logic                    wr_en;
  logic [IDXW-1:0]         wr_addr;
  logic [WORD_W-1:0]       wr_data;
  logic [IDXW-1:0]         rd_addr;
  logic [WORD_W-1:0]       rd_data;
  logic                    rd_ok;

  // Output register.
  logic                    out_valid;
  logic [WORD_W-1:0]       out_word;
  logic [WORD_W-1:0]       emit_word;
  logic                    emit_go;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= RANGE_LOW_RST;
      range_high  <= RANGE_HIGH_RST;
      interp_mode <= MODE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_LOW:   range_low   <= cfg_data;
        CFG_RANGE_HIGH:  range_high  <= cfg_data;
        CFG_INTERP_MODE: interp_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the range; low bound is tested first.
  assign clamp_calc = (item_pos < range_low) ? range_low :
                      ((item_pos > range_high) ? range_high : item_pos);

  // Offset from the low bound, floored to a table index and saturated.
  assign idx_diff = {clamp_val[POS_W-1], clamp_val} - {range_low[POS_W-1], range_low};
  always_comb begin
    if (idx_diff[POS_W]) begin
      idx_calc = '0;
    end else if (idx_diff[POS_W-1:8] > (POS_W - 8)'(TABLE_DEPTH - 1)) begin
      idx_calc = IDXW'(TABLE_DEPTH - 1);
    end else begin
      idx_calc = idx_diff[IDXW+7:8];
    end
  end

  assign span        = new_idx - prev_index;
  assign fill_needed = {1'b0, new_idx} > ({1'b0, prev_index} + (IDXW + 1)'(1));
  assign busy_any    = idx_busy || (|lane_busy);
  assign fill_load   = (state == ST_DIVIDE) && !busy_any;
  assign s0_valid    = (state == ST_FILL) && (fill_k != '0);
  assign s0_addr     = prev_index + fill_k;

  // Lane control.
  assign lane_ctl.start = (state == ST_SETUP) && fill_needed;
  assign lane_ctl.load  = fill_load;
  assign lane_ctl.step  = (state == ST_FILL);
  assign lane_ctl.mode  = interp_mode;

  // One lane per color channel.
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    cgtb_lane #(
      .DENW (IDXW)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (lane_ctl),
      .a     (prev_color[COLOR_W*c +: COLOR_W]),
      .b     (item_color[COLOR_W*c +: COLOR_W]),
      .n     (span),
      .rom_q (rom_q),
      .busy  (lane_busy[c]),
      .res   (lane_res[COLOR_W*c +: COLOR_W])
    );
  end

  // Step of the ROM index: POW_ROM_DEPTH / span.
  cgtb_div #(
    .NUMW (EW),
    .DENW (IDXW)
  ) u_idx_div (
    .clk   (clk),
    .rst   (rst),
    .start (lane_ctl.start),
    .num   (EW'(POW_ROM_DEPTH)),
    .den   (span),
    .busy  (idx_busy),
    .quot  (idx_quot),
    .rem   (idx_rem)
  );

  // Power ROM contents.
  for (genvar j = 0; j < POW_ROM_DEPTH; j++) begin : g_rom
    localparam logic [ROM_W-1:0] PowVal = pow_entry(j, POW_ROM_DEPTH);
    assign pow_rom[j] = PowVal;
  end

  // Incremental floor(k * POW_ROM_DEPTH / span).
  assign e_sum    = {1'b0, er} + {1'b0, esr};
  assign e_wrap   = e_sum >= {1'b0, span};
  assign e_diff   = e_sum - {1'b0, span};
  assign eidx_sum = {1'b0, eidx} + esq + EW'(e_wrap);

  // Table write port: clearing pass, new point, then filled entries.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_addr;
    wr_data = lane_res;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_SETUP) begin
      wr_en   = 1'b1;
      wr_addr = new_idx;
      wr_data = item_color;
    end else if (s2_valid) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  assign rd_addr = IDXW'(item_read_index);
  assign rd_ok   = 32'(item_read_index) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    rd_data <= store_mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      emit_pend  <= 1'b0;
      clr_addr   <= '0;
      fill_k     <= '0;
      prev_index <= '0;
      prev_color <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      if (emit_pend) begin
        if (emit_go) begin
          emit_pend <= 1'b0;
          state     <= ST_IDLE;
        end
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + IDXW'(1);
            if (clr_addr == IDXW'(TABLE_DEPTH - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (item.valid) begin
              case (item.kind)
                KIND_BEGIN: begin
                  prev_index <= '0;
                  prev_color <= '0;
                  emit_pend  <= 1'b1;
                  state      <= ST_READ;
                end
                KIND_POINT: state <= ST_CLAMP;
                KIND_READ:  state <= ST_READ;
                default: begin
                  emit_pend <= 1'b1;
                  state     <= ST_READ;
                end
              endcase
            end
          end
          ST_READ: emit_pend <= 1'b1;
          ST_CLAMP: state <= ST_INDEX;
          ST_INDEX: state <= ST_SETUP;
          ST_SETUP: begin
            if (fill_needed) begin
              state <= ST_DIVIDE;
            end else begin
              prev_index <= new_idx;
              prev_color <= item_color;
              emit_pend  <= 1'b1;
            end
          end
          ST_DIVIDE: begin
            if (!busy_any) begin
              fill_k <= '0;
              state  <= ST_FILL;
            end
          end
          ST_FILL: begin
            fill_k <= fill_k + IDXW'(1);
            if (fill_k == span - IDXW'(1)) begin
              state <= ST_DRAIN;
            end
          end
          ST_DRAIN: begin
            if (!s1_valid && !s2_valid) begin
              prev_index <= new_idx;
              prev_color <= item_color;
              emit_pend  <= 1'b1;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !emit_pend && item.valid) begin
      item_kind       <= item.kind;
      item_pos        <= item.position;
      item_read_index <= item.read_index;
      item_color      <= {item.in_alpha, item.in_blue, item.in_green, item.in_red};
    end
    if (state == ST_CLAMP) begin
      clamp_val <= clamp_calc;
    end
    if (state == ST_INDEX) begin
      new_idx <= idx_calc;
    end
    if (fill_load) begin
      eidx <= '0;
      er   <= '0;
      esq  <= idx_quot;
      esr  <= idx_rem;
    end else if (state == ST_FILL) begin
      eidx <= eidx_sum[PW-1:0];
      er   <= e_wrap ? e_diff[IDXW-1:0] : e_sum[IDXW-1:0];
    end
    rom_q   <= pow_rom[eidx];
    s1_addr <= s0_addr;
    s2_addr <= s1_addr;
  end

  // Result word: the read entry, zero for every other command.
  assign emit_word = ((item_kind == KIND_READ) && rd_ok) ? rd_data : '0;
  assign emit_go   = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_pend && emit_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend && emit_go) begin
      out_word <= emit_word;
    end
  end

  assign item.ready       = (state == ST_IDLE) && !emit_pend;
  assign result.valid     = out_valid;
  assign result.out_red   = out_word[COLOR_W*0 +: COLOR_W];
  assign result.out_green = out_word[COLOR_W*1 +: COLOR_W];
  assign result.out_blue  = out_word[COLOR_W*2 +: COLOR_W];
  assign result.out_alpha = out_word[COLOR_W*3 +: COLOR_W];

  // Filled entries lie strictly between the last point and the new one.
  `CGTB_ASSERT_IMP(a_fill_in_gap, clk, rst, s0_valid, (s0_addr > prev_index) && (s0_addr < new_idx))
  // The ROM index remainder stays below the span while filling.
  `CGTB_ASSERT_IMP(a_idx_rem_below_span, clk, rst, state == ST_FILL, er < span)
  // Fill writes happen only while filling or draining the pipeline.
  `CGTB_ASSERT_IMP(a_fill_write_window, clk, rst, s2_valid, state == ST_FILL || state == ST_DRAIN)
  // A released result shows up on the output and the block is open again.
  `CGTB_ASSERT_NXT(a_emit_loads_output, clk, rst, emit_pend && emit_go, out_valid && item.ready)

endmodule

`default_nettype wire

FILE: rtl/cgtb_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cgtb_div import cgtb_pkg::*; #(
  parameter int NUMW = 8,
  parameter int DENW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            busy,
  output logic [NUMW-1:0] quot,
  output logic [DENW-1:0] rem
);

  localparam int CW = $clog2(NUMW + 1);

  logic [CW-1:0]   cnt;
  logic [NUMW-1:0] quot_r;
  logic [DENW-1:0] rem_r;
  logic [DENW-1:0] den_r;
  logic [DENW:0]   trial;
  logic [DENW:0]   trial_diff;
  logic            fits;

  // Shift in the next dividend bit and try a subtract.
  assign trial      = {rem_r, quot_r[NUMW-1]};
  assign fits       = trial >= {1'b0, den_r};
  assign trial_diff = trial - {1'b0, den_r};

  // Iteration counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUMW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy) begin
      quot_r <= {quot_r[NUMW-2:0], fits};
      rem_r  <= fits ? trial_diff[DENW-1:0] : trial[DENW-1:0];
    end
  end

  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: rtl/cgtb_lane.sv
`default_nettype none

// One color channel: step division at setup, then an incremental
// quotient/remainder walk for linear fill, a ROM-weighted blend for
// exponential fill, the start color otherwise; res is registered.
module cgtb_lane import cgtb_pkg::*; #(
  parameter int DENW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cgtb_lane_ctl_t     ctl,
  input  logic [COLOR_W-1:0] a,
  input  logic [COLOR_W-1:0] b,
  input  logic [DENW-1:0]    n,
  input  logic [ROM_W-1:0]   rom_q,
  output logic               busy,
  output logic [COLOR_W-1:0] res
);

  localparam int DQW = COLOR_W + 2;
  localparam int PW  = COLOR_W + ROM_W;

  logic               neg;
  logic [COLOR_W-1:0] mag;
  logic [COLOR_W-1:0] div_quot;
  logic [DENW-1:0]    div_rem;
  logic [DQW-1:0]     quot_ext;
  logic [DQW-1:0]     dq_init;
  logic [DENW-1:0]    dr_init;

  logic [COLOR_W-1:0] lin_q;
  logic [DENW-1:0]    lin_r;
  logic [DQW-1:0]     dq;
  logic [DENW-1:0]    dr;
  logic [COLOR_W-1:0] lin_q1;

  logic [DENW:0]      r_sum;
  logic [DENW:0]      r_diff;
  logic               r_wrap;
  logic [DENW-1:0]    r_next;
  logic [DQW-1:0]     q_sum;

  logic [PW-1:0]      prod;
  logic [PW:0]        down_sum;
  logic [COLOR_W-1:0] up_val;
  logic [COLOR_W-1:0] down_val;
  logic [COLOR_W-1:0] res_calc;

  // Magnitude and direction of the color change.
  assign neg = b < a;
  assign mag = neg ? (a - b) : (b - a);

  cgtb_div #(
    .NUMW (COLOR_W),
    .DENW (DENW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.start),
    .num   (mag),
    .den   (n),
    .busy  (busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Floor division of the signed per-entry change by the span.
  assign quot_ext = {2'b00, div_quot};
  always_comb begin
    if (!neg) begin
      dq_init = quot_ext;
      dr_init = div_rem;
    end else if (div_rem == '0) begin
      dq_init = DQW'(0) - quot_ext;
      dr_init = '0;
    end else begin
      dq_init = DQW'(0) - quot_ext - DQW'(1);
      dr_init = n - div_rem;
    end
  end

  // Incremental step: remainder wraps into a quotient carry.
  assign r_sum  = {1'b0, lin_r} + {1'b0, dr};
  assign r_wrap = r_sum >= {1'b0, n};
  assign r_diff = r_sum - {1'b0, n};
  assign r_next = r_wrap ? r_diff[DENW-1:0] : r_sum[DENW-1:0];
  assign q_sum  = {2'b00, lin_q} + dq + DQW'(r_wrap);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lin_q <= a;
      lin_r <= '0;
      dq    <= dq_init;
      dr    <= dr_init;
    end else if (ctl.step) begin
      lin_q <= q_sum[COLOR_W-1:0];
      lin_r <= r_next;
    end
  end

  // Exponential blend: round away from the start color going down.
  assign prod     = PW'(mag) * PW'(rom_q);
  assign up_val   = a + prod[PW-1:ROM_W];
  assign down_sum = {1'b0, prod} + (PW + 1)'(ROM_ROUND);
  assign down_val = a - down_sum[PW-1:ROM_W];

  always_comb begin
    case (ctl.mode)
      MODE_LINEAR: res_calc = lin_q1;
      MODE_EXP:    res_calc = neg ? down_val : up_val;
      default:     res_calc = a;
    endcase
  end

  // Stage registers aligned with the ROM read.
  always_ff @(posedge clk) begin
    lin_q1 <= lin_q;
    res    <= res_calc;
  end

endmodule

`default_nettype wire

FILE: test/gradient_table_checker.sv
`default_nettype none

// Watches the item and result channels of the gradient table builder, keeps
// its own copy of the color table and compares every result word in order.
module gradient_table_checker import cgtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cgtb_in_if                    item,
  cgtb_out_if                   result,
  output int                    mismatches,
  output int                    outstanding
);

  // Lane 0 is red, lane 3 is alpha.
  typedef logic [NUM_LANES-1:0][COLOR_W-1:0] swatch_t;

  localparam int MAX_SHOWN = 30;

  logic [ROM_W-1:0]        gamma_curve [CGTB_POW_ROM_DEPTH];
  swatch_t                 palette [CGTB_TABLE_DEPTH];
  swatch_t                 anchor_color;
  int unsigned             anchor_slot;
  logic signed [POS_W-1:0] span_low;
  logic signed [POS_W-1:0] span_high;
  logic [MODE_W-1:0]       blend_mode;
  swatch_t                 awaited_words [$];
  string                   lane_label [NUM_LANES] = '{"red", "green", "blue", "alpha"};

  // Q0.16 fifth root curve: entry j is the largest y with
  // y^5 * depth <= j * 2^80. The root only grows with j, so one sweep does.
  initial begin
    logic [127:0] probe;
    int unsigned  root;
    root = 0;
    for (int j = 0; j < CGTB_POW_ROM_DEPTH; j++) begin
      probe = 128'(root + 1);
      while (root < 65535 &&
             probe * probe * probe * probe * probe * 128'(CGTB_POW_ROM_DEPTH)
               <= (128'(j) << 80)) begin
        root++;
        probe = 128'(root + 1);
      end
      gamma_curve[j] = root[ROM_W-1:0];
    end
  end

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // One channel of an entry between two control points, k steps out of n.
  function automatic logic [COLOR_W-1:0] blend_lane(int unsigned from_c, int unsigned to_c,
                                                    int unsigned k, int unsigned n);
    int unsigned weight;
    int unsigned mixed;
    case (blend_mode)
      MODE_LINEAR: begin
        mixed = (from_c * (n - k) + to_c * k) / n;
      end
      MODE_EXP: begin
        weight = gamma_curve[(k * CGTB_POW_ROM_DEPTH / n) % CGTB_POW_ROM_DEPTH];
        // Rising channels round down, falling ones round away from the start.
        if (to_c >= from_c) begin
          mixed = from_c + (((to_c - from_c) * weight) >> ROM_W);
        end else begin
          mixed = from_c - (((from_c - to_c) * weight + ROM_ROUND) >> ROM_W);
        end
      end
      default: begin
        mixed = from_c;
      end
    endcase
    return mixed[COLOR_W-1:0];
  endfunction

  // Clamp the position, floor it to an entry, write it and fill the gap
  // back to the previous control point.
  task automatic place_point(logic [POS_W-1:0] raw_pos, swatch_t tint);
    longint      lo_l;
    longint      hi_l;
    longint      pos_l;
    longint      clamped;
    longint      offset;
    int unsigned slot;
    swatch_t     mix;
    lo_l  = longint'(span_low);
    hi_l  = longint'(span_high);
    pos_l = longint'($signed(raw_pos));
    // An inverted range tests the low end first; a negative offset is entry 0.
    clamped = (pos_l < lo_l) ? lo_l : ((pos_l > hi_l) ? hi_l : pos_l);
    offset  = clamped - lo_l;
    if (offset < 0) begin
      slot = 0;
    end else if ((offset >>> 8) > longint'(CGTB_TABLE_DEPTH - 1)) begin
      slot = CGTB_TABLE_DEPTH - 1;
    end else begin
      slot = int'(offset >>> 8);
    end
    palette[slot] = tint;
    for (int unsigned i = anchor_slot + 1; i < slot; i++) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        mix[c] = blend_lane(anchor_color[c], tint[c], i - anchor_slot, slot - anchor_slot);
      end
      palette[i] = mix;
    end
    anchor_slot  = slot;
    anchor_color = tint;
  endtask

  always @(posedge clk) begin
    swatch_t seen;
    swatch_t want;
    if (rst) begin
      foreach (palette[e]) begin
        palette[e] = '0;
      end
      anchor_slot  = 0;
      anchor_color = '0;
      span_low     = RANGE_LOW_RST;
      span_high    = RANGE_HIGH_RST;
      blend_mode   = MODE_LINEAR;
      awaited_words.delete();
    end else begin
      // Register writes only happen while the block is idle.
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LOW:   span_low = cfg_data;
          CFG_RANGE_HIGH:  span_high = cfg_data;
          CFG_INTERP_MODE: blend_mode = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end

      // Compare a delivered result word against the oldest prediction.
      if (result.valid && result.ready) begin
        seen = {result.out_alpha, result.out_blue, result.out_green, result.out_red};
        if (awaited_words.size() == 0) begin
          note_mismatch($sformatf("result word %h arrived with nothing expected", seen));
        end else begin
          want = awaited_words.pop_front();
          for (int c = 0; c < NUM_LANES; c++) begin
            if (seen[c] !== want[c]) begin
              note_mismatch($sformatf("%s is %0d, expected %0d", lane_label[c],
                                      seen[c], want[c]));
            end
          end
        end
      end

      // Every accepted item word yields exactly one result word.
      if (item.valid && item.ready) begin
        want = '0;
        case (item.kind)
          KIND_BEGIN: begin
            anchor_slot  = 0;
            anchor_color = '0;
          end
          KIND_POINT: begin
            place_point(item.position,
                        {item.in_alpha, item.in_blue, item.in_green, item.in_red});
          end
          KIND_READ: begin
            want = palette[item.read_index];
          end
          default: ;
        endcase
        awaited_words.push_back(want);
      end
    end
    outstanding <= awaited_words.size();
  end

endmodule

`default_nettype wire

FILE: test/color_gradient_table_builder_test.sv
`default_nettype none

module color_gradient_table_builder_test import cgtb_pkg::*;;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int LONG_STALL  = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 160;
  localparam int SETTLE      = 300;
  localparam int DRAIN_LIMIT = 50000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    pending_words;

  bit                      sender_idle_on;
  bit                      receiver_idle_on;
  int                      stall_requests;
  int                      stall_served;
  int                      n_words;
  int                      n_begin;
  int                      n_point;
  int                      n_read;
  int                      n_spare;
  int                      n_settings;
  logic signed [POS_W-1:0] win_low;

  cgtb_in_if  item_ch ();
  cgtb_out_if result_ch ();

  color_gradient_table_builder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  gradient_table_checker palette_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (item_ch),
    .result      (result_ch),
    .mismatches  (mismatch_count),
    .outstanding (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog, sized for full-table fills under the worst idling.
  initial begin
    #(12_000_000);
    $display("color_gradient_table_builder test failed");
    $finish;
  end

  // Offer one item word after a random gap and wait until it is taken.
  task automatic offer_word(logic [KIND_W-1:0] k, logic [POS_W-1:0] pos,
                            logic [RIDX_W-1:0] ridx, logic [WORD_W-1:0] tint);
    int unsigned gap;
    gap = sender_idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= k;
    item_ch.position   <= pos;
    item_ch.read_index <= ridx;
    {item_ch.in_alpha, item_ch.in_blue, item_ch.in_green, item_ch.in_red} <= tint;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    n_words++;
    case (k)
      KIND_BEGIN: n_begin++;
      KIND_POINT: n_point++;
      KIND_READ:  n_read++;
      default:    n_spare++;
    endcase
  endtask

  task automatic go_quiet();
    item_ch.valid <= 1'b0;
  endtask

  // Stop offering and wait until every predicted result word has come back.
  task automatic drain();
    go_quiet();
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // New range and blend mode, written only once the block has drained.
  task automatic apply_setting(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                               logic [MODE_W-1:0] mode);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = $urandom;
    mode_word[MODE_W-1:0] = mode;
    drain();
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    write_reg(CFG_INTERP_MODE, mode_word);
    cfg_we <= 1'b0;
    win_low = lo;
    n_settings++;
  endtask

  // Position of a table slot above the low end, with a random fraction.
  function automatic logic [POS_W-1:0] slot_position(int unsigned slot);
    longint p;
    p = longint'(win_low) + longint'(slot) * 256 + longint'($urandom_range(0, 255));
    if (p > 2147483647) begin
      p = 2147483647;
    end
    return p[POS_W-1:0];
  endfunction

  // A well-formed build: begin, then control points in ascending order with
  // reads mixed in. Steps of zero and one exercise the no-fill path.
  task automatic run_build(int points);
    int unsigned slot;
    int unsigned step;
    int unsigned roll;
    offer_word(KIND_BEGIN, $urandom, RIDX_W'($urandom), $urandom);
    slot = 0;
    for (int p = 0; p < points && slot < CGTB_TABLE_DEPTH; p++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        step = 0;
      end else if (roll < 18) begin
        step = 1;
      end else if (roll < 88) begin
        step = $urandom_range(2, 16);
      end else begin
        step = $urandom_range(17, 255);
      end
      slot += step;
      offer_word(KIND_POINT, slot_position(slot), RIDX_W'($urandom), $urandom);
      if ($urandom_range(0, 99) < 40) begin
        offer_word(KIND_READ, $urandom, RIDX_W'($urandom_range(0, 255)), $urandom);
      end
    end
  endtask

  // Result side: random stalls per word, plus one long hold-off on request.
  initial begin
    int unsigned hold;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_served != stall_requests) begin
        hold = LONG_STALL;
        stall_served++;
      end else begin
        hold = receiver_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [POS_W-1:0]  lo_v;
    logic [POS_W-1:0]  hi_v;
    logic [MODE_W-1:0] mode_v;
    int                first_word;
    bit                paused;
    int                guard;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= '0;
    item_ch.position   <= '0;
    item_ch.read_index <= '0;
    item_ch.in_red     <= '0;
    item_ch.in_green   <= '0;
    item_ch.in_blue    <= '0;
    item_ch.in_alpha   <= '0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    win_low          = RANGE_LOW_RST;
    paused           = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values: cleared table, spare
    // kind, fraction dropped, clamping at both ends, no-fill points.
    offer_word(KIND_READ, '0, 8'd0, '0);
    offer_word(KIND_READ, '1, 8'd255, '1);
    offer_word(KIND_SPARE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    offer_word(KIND_BEGIN, '0, '0, '0);
    offer_word(KIND_POINT, 32'h0000_0A80, '0, 32'h7F80_00FF);
    offer_word(KIND_READ, '0, 8'd5, '0);
    offer_word(KIND_POINT, 32'h7FFF_FFFF, '0, 32'hFE01_FF00);
    offer_word(KIND_READ, '0, 8'd11, '0);
    offer_word(KIND_READ, '0, 8'd200, '0);
    offer_word(KIND_READ, '0, 8'd254, '0);
    offer_word(KIND_READ, '0, 8'd255, '0);
    offer_word(KIND_POINT, 32'h8000_0000, '0, 32'h281E_140A);
    offer_word(KIND_READ, '0, 8'd0, '0);
    offer_word(KIND_READ, '0, 8'd1, '0);
    offer_word(KIND_POINT, 32'h0000_0100, '0, 32'h0403_0201);
    offer_word(KIND_POINT, 32'h0000_01FF, '0, 32'h8080_8080);
    offer_word(KIND_READ, '0, 8'd1, '0);

    // Exponential fill, falling on red, green and alpha and flat on blue.
    apply_setting(32'd0, 32'd65280, MODE_EXP);
    offer_word(KIND_BEGIN, '0, '0, '0);
    offer_word(KIND_POINT, 32'h0000_0000, '0, 32'hFFFF_FFFF);
    offer_word(KIND_POINT, 32'h0000_6400, '0, 32'h07FF_8000);
    offer_word(KIND_READ, '0, 8'd50, '0);
    offer_word(KIND_READ, '0, 8'd99, '0);

    // Inverted range: both sides of it land on entry 0.
    apply_setting(32'd4096, 32'(-4096), MODE_SPARE);
    offer_word(KIND_POINT, 32'd5000, '0, 32'h1122_3344);
    offer_word(KIND_POINT, 32'(-100000), '0, 32'h5566_7788);
    offer_word(KIND_READ, '0, 8'd0, '0);

    // Random phases, each with its own register setting and idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lo_v = 32'd0;          hi_v = 32'd65280;      mode_v = MODE_LINEAR; end
        1: begin lo_v = 32'h8000_0000;  hi_v = 32'h7FFF_FFFF;  mode_v = MODE_EXP;    end
        2: begin lo_v = 32'(-5000);     hi_v = 32'd3000;       mode_v = MODE_HOLD;   end
        3: begin lo_v = 32'h7FFF_FF00;  hi_v = 32'h7FFF_FFFF;  mode_v = MODE_SPARE;  end
        4: begin lo_v = 32'd1000;       hi_v = 32'd1000;       mode_v = MODE_LINEAR; end
        5: begin lo_v = 32'd4000;       hi_v = 32'(-4000);     mode_v = MODE_EXP;    end
        6: begin lo_v = 32'(-65280);    hi_v = 32'd0;          mode_v = MODE_EXP;    end
        7: begin lo_v = 32'h8000_0000;  hi_v = 32'h8001_0000;  mode_v = MODE_LINEAR; end
        default: begin
          lo_v   = 32'($urandom_range(0, 200000)) - 32'd100000;
          hi_v   = lo_v + 32'($urandom_range(0, 80000));
          mode_v = MODE_W'($urandom_range(0, 3));
        end
      endcase
      apply_setting(lo_v, hi_v, mode_v);
      sender_idle_on   = (ph % 3) != 1;
      receiver_idle_on = (ph % 4) != 2;
      // Hold the result side off while words keep coming, so the block backs up.
      if (ph == 2) begin
        sender_idle_on = 1'b0;
        stall_requests++;
      end
      first_word = n_words;
      while (n_words - first_word < PHASE_WORDS) begin
        if (ph == 5 && !paused && n_words - first_word >= PHASE_WORDS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 80) begin
          run_build($urandom_range(3, 20));
        end else begin
          // Noise: any kind, any position, unordered.
          repeat ($urandom_range(1, 6)) begin
            offer_word(KIND_W'($urandom_range(0, 3)), $urandom, RIDX_W'($urandom), $urandom);
          end
        end
      end
    end

    // Let the last result words come back, then give the block time to settle.
    go_quiet();
    guard = 0;
    @(posedge clk);
    while (pending_words != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d words: %0d begins, %0d control points, %0d reads, %0d of the spare kind.",
             n_words, n_begin, n_point, n_read, n_spare);
    $display("Used %0d register settings: all blend modes, full, equal and inverted ranges.",
             n_settings);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("color_gradient_table_builder test passed");
    end else begin
      $display("color_gradient_table_builder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: color_gradient_table_builder.f
+incdir+rtl
rtl/cgtb_pkg.sv
rtl/cgtb_in_if.sv
rtl/cgtb_out_if.sv
rtl/cgtb_div.sv
rtl/cgtb_lane.sv
rtl/color_gradient_table_builder.sv
test/gradient_table_checker.sv
test/color_gradient_table_builder_test.sv
